// ----- src/xrg_pkg.sv -----
// xrg_pkg: shared types, codes and constants of the xorshift128 generator.
// Used by xrg_front, xrg_back and the top level; depends on nothing.
`default_nettype none

package xrg_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [2:0] ACT_RAW   = 3'd0;
    localparam logic [2:0] ACT_INT   = 3'd1;
    localparam logic [2:0] ACT_BELOW = 3'd2;
    localparam logic [2:0] ACT_RANGE = 3'd3;
    localparam logic [2:0] ACT_FRAC  = 3'd4;
    localparam logic [2:0] ACT_BOOL  = 3'd5;

    localparam logic [31:0] INIT_A = 32'd0;
    localparam logic [31:0] INIT_B = 32'd842502087;
    localparam logic [31:0] INIT_C = 32'd357987591;
    localparam logic [31:0] INIT_D = 32'd273326509;
    localparam logic [30:0] LOW31  = 31'h7FFF_FFFF;

    localparam int unsigned SHIFT_A = 11;
    localparam int unsigned SHIFT_D = 19;
    localparam int unsigned SHIFT_T = 8;

    localparam logic [5:0] BITS_FULL = 6'd32;

    typedef enum logic [2:0] {
        OP_RAW,
        OP_INT,
        OP_BELOW,
        OP_RANGE,
        OP_WIDE,
        OP_FRAC,
        OP_BOOL,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        bad;
        logic        neg;
        logic [31:0] lo;
        logic [31:0] opnd;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAW,
        S_MUL,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- src/xrg_front.sv -----
// xrg_front: decodes each item into a command and holds it in a small queue.
// Depends on xrg_pkg.
`default_nettype none

module xrg_front #(
    parameter int unsigned P_DEPTH = xrg_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [2:0]    i_action,
    input  wire logic [31:0]   i_lower_bound,
    input  wire logic [31:0]   i_upper_bound,
    output logic               o_q_valid,
    output xrg_pkg::t_cmd      o_q_cmd,
    input  wire logic          i_q_pop
);

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);

    xrg_pkg::t_cmd    cmd;
    logic [31:0]      diff32;
    logic [32:0]      diff33;
    logic [32:0]      mag33;

    xrg_pkg::t_cmd    r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr, rd;

    always_comb begin
        diff32   = i_upper_bound - i_lower_bound;
        diff33   = {i_upper_bound[31], i_upper_bound} - {i_lower_bound[31], i_lower_bound};
        mag33    = diff33[32] ? (~diff33 + 33'd1) : diff33;
        cmd.op   = xrg_pkg::OP_NONE;
        cmd.bad  = 1'b0;
        cmd.neg  = 1'b0;
        cmd.lo   = i_lower_bound;
        cmd.opnd = '0;
        unique case (i_action)
            xrg_pkg::ACT_RAW:   cmd.op = xrg_pkg::OP_RAW;
            xrg_pkg::ACT_INT:   cmd.op = xrg_pkg::OP_INT;
            xrg_pkg::ACT_BELOW: begin
                cmd.op   = xrg_pkg::OP_BELOW;
                cmd.bad  = i_upper_bound[31] || (i_upper_bound == 32'd0);
                cmd.opnd = i_upper_bound;
            end
            xrg_pkg::ACT_RANGE: begin
                if (!diff32[31]) begin
                    cmd.op   = xrg_pkg::OP_RANGE;
                    cmd.opnd = diff32;
                end else begin
                    cmd.op   = xrg_pkg::OP_WIDE;
                    cmd.neg  = diff33[32];
                    cmd.opnd = mag33[31:0];
                end
            end
            xrg_pkg::ACT_FRAC:  cmd.op = xrg_pkg::OP_FRAC;
            xrg_pkg::ACT_BOOL:  cmd.op = xrg_pkg::OP_BOOL;
            default:            cmd.op = xrg_pkg::OP_NONE;
        endcase
    end

    assign full      = (r_count == CNT_W'(P_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_cmd   = r_mem[r_rptr];
    assign wr        = push && !full;
    assign rd        = i_q_pop && o_q_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr) begin
            n_wptr = (r_wptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (rd) begin
            n_rptr = (r_rptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (wr && !rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd && !wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= cmd;
        end
    end

endmodule

`default_nettype wire

// ----- src/xrg_back.sv -----
// xrg_back: generator words, draw/multiply sequencer and the result register.
// Depends on xrg_pkg; takes commands from xrg_front.
`default_nettype none

module xrg_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_seed_we,
    input  wire logic [31:0]   i_seed_wdata,
    input  wire logic          i_q_valid,
    input  wire xrg_pkg::t_cmd i_q_cmd,
    output logic               o_q_pop,
    output logic               empty,
    input  wire logic          pop,
    output logic [31:0]        o_value,
    output logic               o_bad_bound
);

    xrg_pkg::t_state r_state, n_state;
    xrg_pkg::t_cmd   r_cmd;
    logic [31:0]     r_a, r_b, r_c, r_d;
    logic [31:0]     r_bits, n_bits;
    logic [5:0]      r_bits_used, n_bits_used;
    logic [31:0]     r_w, n_w;
    logic [63:0]     r_prod;
    logic            r_out_valid;
    logic [31:0]     r_value, n_value;
    logic            r_bad;

    logic [31:0] step_t, new_d, mul_a;
    logic        out_free, start, need_draw, retry, do_draw, load_out;

    assign out_free = !r_out_valid || pop;
    assign step_t   = r_a ^ (r_a << xrg_pkg::SHIFT_A);
    assign new_d    = r_d ^ (r_d >> xrg_pkg::SHIFT_D) ^ step_t ^ (step_t >> xrg_pkg::SHIFT_T);
    assign need_draw = (r_cmd.op != xrg_pkg::OP_NONE)
                    && ((r_cmd.op != xrg_pkg::OP_BOOL) || r_bits_used[5]);
    assign retry    = (r_cmd.op == xrg_pkg::OP_INT) && (new_d[30:0] == xrg_pkg::LOW31);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            xrg_pkg::S_IDLE: if (i_q_valid && out_free) n_state = xrg_pkg::S_DRAW;
            xrg_pkg::S_DRAW: if (!retry) n_state = xrg_pkg::S_MUL;
            xrg_pkg::S_MUL:  n_state = xrg_pkg::S_OUT;
            xrg_pkg::S_OUT:  n_state = xrg_pkg::S_IDLE;
            default:         n_state = xrg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        start    = 1'b0;
        do_draw  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            xrg_pkg::S_IDLE: start    = i_q_valid && out_free;
            xrg_pkg::S_DRAW: do_draw  = need_draw;
            xrg_pkg::S_MUL:  ;
            xrg_pkg::S_OUT:  load_out = 1'b1;
            default:         ;
        endcase
    end

    assign o_q_pop = start;

    always_comb begin
        n_w         = new_d;
        n_bits      = r_bits;
        n_bits_used = r_bits_used;
        if (r_cmd.op == xrg_pkg::OP_BOOL) begin
            if (r_bits_used[5]) begin
                n_bits      = new_d;
                n_bits_used = 6'd1;
            end else begin
                n_bits      = r_bits >> 1;
                n_bits_used = r_bits_used + 6'd1;
            end
            n_w = n_bits;
        end
    end

    assign mul_a = (r_cmd.op == xrg_pkg::OP_WIDE) ? r_w : {1'b0, r_w[30:0]};

    always_comb begin
        unique case (r_cmd.op)
            xrg_pkg::OP_RAW:   n_value = r_w;
            xrg_pkg::OP_INT,
            xrg_pkg::OP_FRAC:  n_value = {1'b0, r_w[30:0]};
            xrg_pkg::OP_BELOW: n_value = r_cmd.bad ? 32'd0 : r_prod[62:31];
            xrg_pkg::OP_RANGE: n_value = r_cmd.lo + r_prod[62:31];
            xrg_pkg::OP_WIDE:  n_value = r_cmd.neg ? (r_cmd.lo - r_prod[63:32])
                                                   : (r_cmd.lo + r_prod[63:32]);
            xrg_pkg::OP_BOOL:  n_value = {31'd0, r_w[0]};
            default:           n_value = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xrg_pkg::S_IDLE;
            r_a         <= xrg_pkg::INIT_A;
            r_b         <= xrg_pkg::INIT_B;
            r_c         <= xrg_pkg::INIT_C;
            r_d         <= xrg_pkg::INIT_D;
            r_bits      <= '0;
            r_bits_used <= xrg_pkg::BITS_FULL;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_seed_we) begin
                r_a <= i_seed_wdata;
                r_b <= xrg_pkg::INIT_B;
                r_c <= xrg_pkg::INIT_C;
                r_d <= xrg_pkg::INIT_D;
            end else if (do_draw) begin
                r_a <= r_b;
                r_b <= r_c;
                r_c <= r_d;
                r_d <= new_d;
            end
            if (r_state == xrg_pkg::S_DRAW) begin
                r_bits      <= n_bits;
                r_bits_used <= n_bits_used;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd <= i_q_cmd;
        end
        if (r_state == xrg_pkg::S_DRAW) begin
            r_w <= n_w;
        end
        if (r_state == xrg_pkg::S_MUL) begin
            r_prod <= {32'd0, mul_a} * {32'd0, r_cmd.opnd};
        end
        if (load_out) begin
            r_value <= n_value;
            r_bad   <= (r_cmd.op == xrg_pkg::OP_BELOW) && r_cmd.bad;
        end
    end

    assign empty       = !r_out_valid;
    assign o_value     = r_value;
    assign o_bad_bound = r_bad;

endmodule

`default_nettype wire

// ----- src/xorshift128_random_generator.sv -----
// Flow: push writes the queue, then the back end runs each item through its draw,
// multiply and result states; an int31 draw with bits 30:0 all ones is redrawn.
// One item at a time, once the result is free; 32x32 multiplier, one step per draw.
// Reset: synchronous active low; words load the default seed, bit buffer empty.
// Top level of the xorshift128 generator; depends on xrg_pkg, xrg_front, xrg_back.
`default_nettype none

module xorshift128_random_generator #(
    parameter int unsigned P_QUEUE_DEPTH = xrg_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_seed_we,
    input  wire logic [31:0]   i_seed_wdata,
    input  wire logic          push,
    output logic               full,
    input  wire logic [2:0]    i_action,
    input  wire logic [31:0]   i_lower_bound,
    input  wire logic [31:0]   i_upper_bound,
    output logic               empty,
    input  wire logic          pop,
    output logic [31:0]        o_value,
    output logic               o_bad_bound
);

    logic          q_valid;
    logic          q_pop;
    xrg_pkg::t_cmd q_cmd;

    xrg_front #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .o_q_valid     (q_valid),
        .o_q_cmd       (q_cmd),
        .i_q_pop       (q_pop)
    );

    xrg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_wdata (i_seed_wdata),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_q_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_value      (o_value),
        .o_bad_bound  (o_bad_bound)
    );

endmodule

`default_nettype wire

// ----- src/xrg_checker.sv -----
// xrg_assert: port-level assertions for the xorshift128 generator.
// Bound to xorshift128_random_generator; depends on nothing else.
`default_nettype none

module xrg_assert (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] o_value,
    input wire logic        o_bad_bound
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("result or full flag left after reset");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_bad_bound) |-> (o_value == 32'd0))
        else $error("bad bound item carries a nonzero value");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_value) && $stable(o_bad_bound)))
        else $error("waiting item changed or vanished");

    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !$isunknown({o_value, o_bad_bound}))
        else $error("waiting item has unknown bits");

endmodule

bind xorshift128_random_generator xrg_assert u_xrg_assert (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_value     (o_value),
    .o_bad_bound (o_bad_bound)
);

`default_nettype wire
